@@ sv/in_place_row_permuter_top_assert.svh @@
// Assertion macros for the in-place row permuter.
// Used by the top level only; no other dependencies.
`ifndef IN_PLACE_ROW_PERMUTER_TOP_ASSERT_SVH
`define IN_PLACE_ROW_PERMUTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define IPP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("in_place_row_permuter: assertion failed");
`define IPP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("in_place_row_permuter: assertion failed");
`else
`define IPP_ASSERT(lbl, clk, rstn, prop)
`define IPP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ sv/ipp_pkg.sv @@
// Package of the in-place row permuter: field widths, codes, payload types.
// No dependencies; imported by ipp_row_tbl, ipp_ctrl and the top level.
`default_nettype none

package ipp_pkg;

  localparam int unsigned MAX_ROWS_DEF  = 1024;
  localparam int unsigned MAX_WORDS_DEF = 8;
  localparam int unsigned WORD_BITS_DEF = 32;

  localparam int unsigned ITEM_COUNT_W = 11;
  localparam int unsigned ROW_WORDS_W  = 4;
  localparam int unsigned BASE_ROW_W   = 10;
  localparam int unsigned ROW_W        = 10;
  localparam int unsigned WORD_IDX_W   = 3;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned DEST_W       = 10;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 11;

  typedef enum logic [1:0] {
    CMD_WRITE_WORD = 2'd0,
    CMD_WRITE_DEST = 2'd1,
    CMD_RUN        = 2'd2,
    CMD_READ_WORD  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_PERM = 2'd1,
    STATUS_ADDR_ERR = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ITEM_COUNT = 2'd0,
    REG_ROW_WORDS  = 2'd1,
    REG_BASE_ROW   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_SCAN_CHK,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_DEST_RD,
    ST_DEST_CHK,
    ST_XCHG_RD,
    ST_XCHG_WR,
    ST_MARK
  } state_e;

  typedef struct packed {
    cmd_e                         command;
    logic [ROW_W-1:0]             row_index;
    logic [WORD_IDX_W-1:0]        word_index;
    logic signed [VALUE_W-1:0]    word_value;
    logic [DEST_W-1:0]            dest_row;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    status_e                   status;
  } rsp_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;
  } cfg_wr_t;

  typedef struct packed {
    logic [ITEM_COUNT_W-1:0] item_count;
    logic [ROW_WORDS_W-1:0]  row_words;
    logic [BASE_ROW_W-1:0]   base_row;
  } cfg_regs_t;

  typedef struct packed {
    logic busy;
    logic run_done;
  } ctrl_stat_t;

endpackage

`default_nettype wire

@@ sv/ipp_chan_if.sv @@
// Valid/ready channel interface carrying one payload struct per request.
// The payload type is given by the instantiating module.
`default_nettype none

interface ipp_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ sv/ipp_row_mem.sv @@
// Row store of the permuter: one synchronous memory, one write and one read port.
// Read data is registered and holds until the next read. Depends on nothing.
`default_nettype none

module ipp_row_mem #(
  parameter int unsigned Depth = 8192,
  parameter int unsigned Width = 32,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/ipp_row_tbl.sv @@
// Per-row tables of the permuter: destination table and visited bits.
// Both are synchronous memories with registered read data. Uses ipp_pkg.
`default_nettype none

module ipp_row_tbl #(
  parameter int unsigned MaxRows = 1024,
  localparam int unsigned RowAw = $clog2(MaxRows)
) (
  input  logic                      clk_i,
  input  logic                      dest_we_i,
  input  logic [RowAw-1:0]          dest_waddr_i,
  input  logic [ipp_pkg::DEST_W-1:0] dest_wdata_i,
  input  logic                      dest_re_i,
  input  logic [RowAw-1:0]          dest_raddr_i,
  output logic [ipp_pkg::DEST_W-1:0] dest_rdata_o,
  input  logic                      vis_we_i,
  input  logic [RowAw-1:0]          vis_waddr_i,
  input  logic                      vis_wdata_i,
  input  logic                      vis_re_i,
  input  logic [RowAw-1:0]          vis_raddr_i,
  output logic                      vis_rdata_o
);
  import ipp_pkg::*;

  logic [DEST_W-1:0] dest_mem [MaxRows];
  logic              vis_mem  [MaxRows];
  logic [DEST_W-1:0] dest_rdata_q;
  logic              vis_rdata_q;

  always_ff @(posedge clk_i) begin
    if (dest_we_i) begin
      dest_mem[dest_waddr_i] <= dest_wdata_i;
    end
    if (dest_re_i) begin
      dest_rdata_q <= dest_mem[dest_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vis_we_i) begin
      vis_mem[vis_waddr_i] <= vis_wdata_i;
    end
    if (vis_re_i) begin
      vis_rdata_q <= vis_mem[vis_raddr_i];
    end
  end

  assign dest_rdata_o = dest_rdata_q;
  assign vis_rdata_o  = vis_rdata_q;

endmodule

`default_nettype wire

@@ sv/ipp_ctrl.sv @@
// Command decoder and cycle-following sequencer of the permuter.
// Drives the row store and the per-row tables; holds the carry row and the
// response stage. Uses ipp_pkg and ipp_chan_if.
`default_nettype none

module ipp_ctrl #(
  parameter int unsigned MaxRows  = 1024,
  parameter int unsigned MaxWords = 8,
  parameter int unsigned WordBits = 32,
  localparam int unsigned StoreAw = $clog2(MaxRows * MaxWords),
  localparam int unsigned RowAw   = $clog2(MaxRows)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ipp_pkg::cfg_regs_t         cfg_i,
  ipp_chan_if.sink                   req_if,
  ipp_chan_if.source                 rsp_if,
  output logic                       row_we_o,
  output logic [StoreAw-1:0]         row_waddr_o,
  output logic [WordBits-1:0]        row_wdata_o,
  output logic                       row_re_o,
  output logic [StoreAw-1:0]         row_raddr_o,
  input  logic [WordBits-1:0]        row_rdata_i,
  output logic                       dest_we_o,
  output logic [RowAw-1:0]           dest_waddr_o,
  output logic [ipp_pkg::DEST_W-1:0] dest_wdata_o,
  output logic                       dest_re_o,
  output logic [RowAw-1:0]           dest_raddr_o,
  input  logic [ipp_pkg::DEST_W-1:0] dest_rdata_i,
  output logic                       vis_we_o,
  output logic [RowAw-1:0]           vis_waddr_o,
  output logic                       vis_wdata_o,
  output logic                       vis_re_o,
  output logic [RowAw-1:0]           vis_raddr_o,
  input  logic                       vis_rdata_i,
  output ipp_pkg::ctrl_stat_t        stat_o
);
  import ipp_pkg::*;

  localparam int unsigned StoreWords = MaxRows * MaxWords;
  localparam int unsigned RwW        = $clog2(MaxWords + 1);
  localparam int unsigned WIdxW      = (MaxWords > 1) ? $clog2(MaxWords) : 1;
  localparam int unsigned CntW       = ITEM_COUNT_W;
  localparam int unsigned SumW       = CntW + 1;
  localparam int unsigned ProdW      = SumW + RwW;
  localparam int unsigned CmpW       = (ProdW > StoreAw + 1) ? ProdW : StoreAw + 1;

  state_e               state_q, state_d;
  logic [CntW-1:0]      i_q, i_d;
  logic [CntW-1:0]      src_q, src_d;
  logic [CntW-1:0]      dst_q, dst_d;
  logic [CntW-1:0]      steps_q, steps_d;
  logic [RwW-1:0]       j_q, j_d;
  logic [StoreAw-1:0]   row_base_q, row_base_d;
  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_read_q, s1_read_d;
  status_e              s1_status_q, s1_status_d;
  logic [WordBits-1:0]  carry_q [MaxWords];

  req_t                 req;
  rsp_t                 rsp;
  logic                 acc;
  logic [RwW-1:0]       rw;
  logic [CntW-1:0]      n;
  logic [CntW-1:0]      mul_x;
  logic [SumW-1:0]      mul_sum;
  logic [ProdW-1:0]     mul_prod;
  logic [CmpW-1:0]      cmd_addr;
  logic                 word_bad;
  logic                 dest_bad;
  logic                 run_bad;
  logic                 last_word;
  logic                 i_last;
  logic [CntW-1:0]      steps_inc;
  logic [StoreAw-1:0]   run_addr;
  logic                 carry_we;
  logic                 run_fin;
  status_e              run_status;

  assign req = req_if.payload;
  assign n   = cfg_i.item_count;

  // Effective row length, clamped to 1..MaxWords.
  always_comb begin
    if (cfg_i.row_words == '0) begin
      rw = RwW'(1);
    end else if (32'(cfg_i.row_words) > MaxWords) begin
      rw = RwW'(MaxWords);
    end else begin
      rw = RwW'(cfg_i.row_words);
    end
  end

  // One shared multiplier gives (x + base_row) * rw: window end for the range
  // check, and the first word address of the row being loaded or exchanged.
  always_comb begin
    unique case (state_q)
      ST_IDLE:     mul_x = n;
      ST_SCAN_CHK: mul_x = i_q;
      default:     mul_x = CntW'(dest_rdata_i);
    endcase
  end

  assign mul_sum  = SumW'(mul_x) + SumW'(cfg_i.base_row);
  assign mul_prod = ProdW'(mul_sum) * ProdW'(rw);

  assign cmd_addr = CmpW'(req.row_index) * CmpW'(rw) + CmpW'(req.word_index);
  assign word_bad = (8'(req.word_index) >= 8'(rw)) || (cmd_addr >= CmpW'(StoreWords));
  assign dest_bad = 32'(req.row_index) >= MaxRows;
  assign run_bad  = (32'(n) > MaxRows) || (CmpW'(mul_prod) > CmpW'(StoreWords));

  assign last_word = (j_q == (rw - RwW'(1)));
  assign i_last    = ((i_q + CntW'(1)) == n);
  assign steps_inc = steps_q + CntW'(1);
  assign run_addr  = row_base_q + StoreAw'(j_q);

  assign req_if.ready = (state_q == ST_IDLE) && (!s1_valid_q || rsp_if.ready);
  assign acc          = req_if.valid && req_if.ready;

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    src_d       = src_q;
    dst_d       = dst_q;
    steps_d     = steps_q;
    j_d         = j_q;
    row_base_d  = row_base_q;
    s1_valid_d  = s1_valid_q && !rsp_if.ready;
    s1_read_d   = s1_read_q;
    s1_status_d = s1_status_q;
    run_fin     = 1'b0;
    run_status  = STATUS_OK;
    carry_we    = 1'b0;

    row_we_o     = 1'b0;
    row_waddr_o  = run_addr;
    row_wdata_o  = carry_q[j_q[WIdxW-1:0]];
    row_re_o     = 1'b0;
    row_raddr_o  = run_addr;
    dest_we_o    = 1'b0;
    dest_waddr_o = RowAw'(req.row_index);
    dest_wdata_o = req.dest_row;
    dest_re_o    = 1'b0;
    dest_raddr_o = RowAw'(src_q);
    vis_we_o     = 1'b0;
    vis_waddr_o  = RowAw'(i_q);
    vis_wdata_o  = 1'b0;
    vis_re_o     = 1'b0;
    vis_raddr_o  = RowAw'(i_q);

    unique case (state_q)
      ST_IDLE: begin
        row_waddr_o = StoreAw'(cmd_addr);
        row_raddr_o = StoreAw'(cmd_addr);
        row_wdata_o = WordBits'(req.word_value);
        if (acc) begin
          s1_valid_d  = 1'b1;
          s1_read_d   = 1'b0;
          s1_status_d = STATUS_OK;
          unique case (req.command)
            CMD_WRITE_WORD: begin
              if (word_bad) begin
                s1_status_d = STATUS_ADDR_ERR;
              end else begin
                row_we_o = 1'b1;
              end
            end
            CMD_READ_WORD: begin
              if (word_bad) begin
                s1_status_d = STATUS_ADDR_ERR;
              end else begin
                row_re_o  = 1'b1;
                s1_read_d = 1'b1;
              end
            end
            CMD_WRITE_DEST: begin
              if (dest_bad) begin
                s1_status_d = STATUS_ADDR_ERR;
              end else begin
                dest_we_o = 1'b1;
              end
            end
            CMD_RUN: begin
              if (run_bad) begin
                s1_status_d = STATUS_ADDR_ERR;
              end else if (n != '0) begin
                // The response is held back until the run ends.
                s1_valid_d = 1'b0;
                i_d        = '0;
                state_d    = ST_CLEAR;
              end
            end
          endcase
        end
      end
      ST_CLEAR: begin
        vis_we_o = 1'b1;
        if (i_last) begin
          i_d     = '0;
          state_d = ST_SCAN;
        end else begin
          i_d = i_q + CntW'(1);
        end
      end
      ST_SCAN: begin
        vis_re_o = 1'b1;
        state_d  = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (vis_rdata_i) begin
          if (i_last) begin
            run_fin = 1'b1;
          end else begin
            i_d     = i_q + CntW'(1);
            state_d = ST_SCAN;
          end
        end else begin
          src_d      = i_q;
          steps_d    = '0;
          j_d        = '0;
          row_base_d = StoreAw'(mul_prod);
          state_d    = ST_LOAD_RD;
        end
      end
      ST_LOAD_RD: begin
        row_re_o = 1'b1;
        state_d  = ST_LOAD_WR;
      end
      ST_LOAD_WR: begin
        carry_we = 1'b1;
        if (last_word) begin
          state_d = ST_DEST_RD;
        end else begin
          j_d     = j_q + RwW'(1);
          state_d = ST_LOAD_RD;
        end
      end
      ST_DEST_RD: begin
        dest_re_o = 1'b1;
        state_d   = ST_DEST_CHK;
      end
      ST_DEST_CHK: begin
        if (CntW'(dest_rdata_i) >= n) begin
          run_fin    = 1'b1;
          run_status = STATUS_BAD_PERM;
        end else begin
          dst_d      = CntW'(dest_rdata_i);
          row_base_d = StoreAw'(mul_prod);
          j_d        = '0;
          state_d    = ST_XCHG_RD;
        end
      end
      ST_XCHG_RD: begin
        row_re_o = 1'b1;
        state_d  = ST_XCHG_WR;
      end
      ST_XCHG_WR: begin
        // The stored word goes out and the old one takes its place in the
        // carry row; the read finished in the previous cycle.
        row_we_o = 1'b1;
        carry_we = 1'b1;
        if (last_word) begin
          state_d = ST_MARK;
        end else begin
          j_d     = j_q + RwW'(1);
          state_d = ST_XCHG_RD;
        end
      end
      ST_MARK: begin
        vis_we_o    = 1'b1;
        vis_waddr_o = RowAw'(dst_q);
        vis_wdata_o = 1'b1;
        src_d       = dst_q;
        steps_d     = steps_inc;
        if (dst_q == i_q) begin
          if (i_last) begin
            run_fin = 1'b1;
          end else begin
            i_d     = i_q + CntW'(1);
            state_d = ST_SCAN;
          end
        end else if (steps_inc >= n) begin
          run_fin    = 1'b1;
          run_status = STATUS_BAD_PERM;
        end else begin
          state_d = ST_DEST_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (run_fin) begin
      s1_valid_d  = 1'b1;
      s1_read_d   = 1'b0;
      s1_status_d = run_status;
      state_d     = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      steps_q     <= '0;
      j_q         <= '0;
      s1_valid_q  <= 1'b0;
      s1_read_q   <= 1'b0;
      s1_status_q <= STATUS_OK;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      src_q       <= src_d;
      dst_q       <= dst_d;
      steps_q     <= steps_d;
      j_q         <= j_d;
      s1_valid_q  <= s1_valid_d;
      s1_read_q   <= s1_read_d;
      s1_status_q <= s1_status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_base_q <= row_base_d;
    if (carry_we) begin
      carry_q[j_q[WIdxW-1:0]] <= row_rdata_i;
    end
  end

  assign rsp.read_value = s1_read_q ? VALUE_W'(row_rdata_i) : '0;
  assign rsp.status     = s1_status_q;
  assign rsp_if.valid   = s1_valid_q;
  assign rsp_if.payload = rsp;

  assign stat_o.busy     = (state_q != ST_IDLE);
  assign stat_o.run_done = run_fin;

endmodule

`default_nettype wire

@@ sv/in_place_row_permuter_top.sv @@
// Word and destination commands answer in the cycle after acceptance,
// one request per cycle while responses are taken. A run holds off requests
// and answers when it ends; every row word is read and written in separate
// states. Reset clears control state and configuration (row length resets
// to one word); memory contents stay undefined, and visited bits are swept
// clear at the start of every run.
// Top level of the in-place row permuter: configuration registers, the
// sequencer and its memories. Uses ipp_pkg, ipp_chan_if, ipp_ctrl,
// ipp_row_mem, ipp_row_tbl and the assertion macro header.
`default_nettype none
`include "in_place_row_permuter_top_assert.svh"

module in_place_row_permuter_top #(
  parameter int unsigned MaxRows  = ipp_pkg::MAX_ROWS_DEF,
  parameter int unsigned MaxWords = ipp_pkg::MAX_WORDS_DEF,
  parameter int unsigned WordBits = ipp_pkg::WORD_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ipp_chan_if.sink   req_if,
  ipp_chan_if.source rsp_if,
  ipp_chan_if.sink   cfg_if
);
  import ipp_pkg::*;

  localparam int unsigned StoreWords = MaxRows * MaxWords;
  localparam int unsigned StoreAw    = $clog2(StoreWords);
  localparam int unsigned RowAw      = $clog2(MaxRows);

  // Configuration registers. The host must write them only while the block is
  // idle, which the block does not enforce; they feed the sequencer directly without shadowing.
  cfg_regs_t cfg_q, cfg_d;
  cfg_wr_t   cfg_wr;
  logic      cfg_acc;

  assign cfg_wr       = cfg_if.payload;
  assign cfg_if.ready = 1'b1;
  assign cfg_acc      = cfg_if.valid && cfg_if.ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_acc) begin
      // Indexes past the register list are accepted and dropped.
      unique case (cfg_wr.reg_index)
        REG_ITEM_COUNT: cfg_d.item_count = cfg_wr.wr_data[ITEM_COUNT_W-1:0];
        REG_ROW_WORDS:  cfg_d.row_words  = cfg_wr.wr_data[ROW_WORDS_W-1:0];
        REG_BASE_ROW:   cfg_d.base_row   = cfg_wr.wr_data[BASE_ROW_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.item_count <= '0;
      cfg_q.row_words  <= ROW_WORDS_W'(1);
      cfg_q.base_row   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Memory ports between the sequencer and the stores.
  logic                row_we;
  logic [StoreAw-1:0]  row_waddr;
  logic [WordBits-1:0] row_wdata;
  logic                row_re;
  logic [StoreAw-1:0]  row_raddr;
  logic [WordBits-1:0] row_rdata;
  logic                dest_we;
  logic [RowAw-1:0]    dest_waddr;
  logic [DEST_W-1:0]   dest_wdata;
  logic                dest_re;
  logic [RowAw-1:0]    dest_raddr;
  logic [DEST_W-1:0]   dest_rdata;
  logic                vis_we;
  logic [RowAw-1:0]    vis_waddr;
  logic                vis_wdata;
  logic                vis_re;
  logic [RowAw-1:0]    vis_raddr;
  logic                vis_rdata;
  ctrl_stat_t          stat;

  // The sequencer decodes requests and, for a run, walks each permutation
  // cycle: load the start row into the carry buffer, then for every hop read
  // the destination, swap the carry row with the destination row word by
  // word, and mark the destination visited.
  ipp_ctrl #(
    .MaxRows  (MaxRows),
    .MaxWords (MaxWords),
    .WordBits (WordBits)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .req_if       (req_if),
    .rsp_if       (rsp_if),
    .row_we_o     (row_we),
    .row_waddr_o  (row_waddr),
    .row_wdata_o  (row_wdata),
    .row_re_o     (row_re),
    .row_raddr_o  (row_raddr),
    .row_rdata_i  (row_rdata),
    .dest_we_o    (dest_we),
    .dest_waddr_o (dest_waddr),
    .dest_wdata_o (dest_wdata),
    .dest_re_o    (dest_re),
    .dest_raddr_o (dest_raddr),
    .dest_rdata_i (dest_rdata),
    .vis_we_o     (vis_we),
    .vis_waddr_o  (vis_waddr),
    .vis_wdata_o  (vis_wdata),
    .vis_re_o     (vis_re),
    .vis_raddr_o  (vis_raddr),
    .vis_rdata_i  (vis_rdata),
    .stat_o       (stat)
  );

  // Row store: all data words, rows laid out back to back.
  ipp_row_mem #(
    .Depth (StoreWords),
    .Width (WordBits)
  ) u_row_mem (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .re_i    (row_re),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  // Destination table and visited bits, one entry per window row.
  ipp_row_tbl #(
    .MaxRows (MaxRows)
  ) u_row_tbl (
    .clk_i        (clk_i),
    .dest_we_i    (dest_we),
    .dest_waddr_i (dest_waddr),
    .dest_wdata_i (dest_wdata),
    .dest_re_i    (dest_re),
    .dest_raddr_i (dest_raddr),
    .dest_rdata_o (dest_rdata),
    .vis_we_i     (vis_we),
    .vis_waddr_i  (vis_waddr),
    .vis_wdata_i  (vis_wdata),
    .vis_re_i     (vis_re),
    .vis_raddr_i  (vis_raddr),
    .vis_rdata_o  (vis_rdata)
  );

  // The response register is cleared by reset, so no response is valid during reset.
  `IPP_ASSERT_ALWAYS(a_rsp_quiet_in_reset, clk_i, !rst_ni |-> !rsp_if.valid)
  // No new request may slip in while a run owns the memories.
  `IPP_ASSERT(a_busy_blocks_req, clk_i, rst_ni, stat.busy |-> !req_if.ready)
  // The exchange is serialized, so the row store never reads and writes at once.
  `IPP_ASSERT(a_row_mem_no_overlap, clk_i, rst_ni, !(row_we && row_re))
  // An accepted run either starts the sequencer or answers at once.
  `IPP_ASSERT(a_run_starts, clk_i, rst_ni, (req_if.valid && req_if.ready && req_if.payload.command == CMD_RUN) |=> (stat.busy || rsp_if.valid))
  // The end of a run always leaves its status in the response register.
  `IPP_ASSERT(a_run_done_rsp, clk_i, rst_ni, stat.run_done |=> rsp_if.valid)

endmodule

`default_nettype wire
